[src/prh_pkg.sv]
// shared types and constants of the polynomial rolling hash bucket unit
package prh_pkg;

   localparam int HASH_W   = 31;
   localparam int BKT_W    = 21;
   localparam int IDX_W    = 20;
   localparam int BYTE_W   = 8;
   localparam int CNT_W    = $clog2(HASH_W);
   localparam int CSR_A_W  = 2;
   localparam int RSP_D_W  = ((HASH_W + IDX_W + 7) / 8) * 8;

   localparam logic [CSR_A_W-1:0] CSR_HASH_BASE    = 2'd0;
   localparam logic [CSR_A_W-1:0] CSR_HASH_MODULUS = 2'd1;
   localparam logic [CSR_A_W-1:0] CSR_BUCKET_COUNT = 2'd2;

   localparam logic [HASH_W-1:0] BASE_RST    = 31'd257;
   localparam logic [HASH_W-1:0] MODULUS_RST = 31'd1761471161;
   localparam logic [BKT_W-1:0]  BUCKET_RST  = 21'd5;
   localparam logic [BKT_W-1:0]  BUCKET_MAX  = 21'd1048576;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_MUL,
      ST_ADD,
      ST_BUCKET,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic idle;
      logic load;
      logic reduce;
      logic mul;
      logic add;
      logic bucket;
      logic emit;
   } ctl_type;

endpackage

[src/polynomial_rolling_hash_bucket_unit.sv]
// top level of the polynomial rolling hash bucket unit
// Hashes a key one byte per beat: hash = (hash + byte*power) mod modulus and
// power = power*base mod modulus, all arithmetic exact. A byte beat is taken
// only while the unit is idle and occupies it from then on: the idle cycle
// that loads it, bit-serial reduction of the base, the byte and the running
// hash below the modulus, shift-and-add multiplication over the bits of the
// running power, and adding the old hash. A byte with tlast then adds the
// bit-serial hash mod bucket_count and the load of the result register,
// which then waits for the consumer while the next key starts; that load
// stretches for as long as an earlier result still waits unread. All
// operands of these steps are 31 bits wide.
module polynomial_rolling_hash_bucket_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [prh_pkg::BYTE_W-1:0]  req_tdata,  // key_byte
   input  logic                        req_tlast,  // last_byte
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [prh_pkg::RSP_D_W-1:0] rsp_tdata,  // key_hash, bucket_index, zero fill
   input  logic                        csr_we,
   input  logic [prh_pkg::CSR_A_W-1:0] csr_addr,
   input  logic [prh_pkg::HASH_W-1:0]  csr_wdata
);
   import prh_pkg::*;

   ctl_type ctl;
   logic    rsp_busy;

   logic [HASH_W-1:0] base_cfg_ff, base_cfg_in;
   logic [HASH_W-1:0] mod_cfg_ff, mod_cfg_in;
   logic [BKT_W-1:0]  bkt_cfg_ff, bkt_cfg_in;
   logic [HASH_W-1:0] m_eff;
   logic [HASH_W-1:0] bkt_eff;

   logic [HASH_W-1:0] rh_ff, rh_in;
   logic [HASH_W-1:0] bp_ff, bp_in;
   logic [HASH_W-1:0] rh_sr_ff, rh_sr_in;
   logic [HASH_W-1:0] base_sr_ff, base_sr_in;
   logic [HASH_W-1:0] byte_sr_ff, byte_sr_in;
   logic [HASH_W-1:0] bp_sr_ff, bp_sr_in;
   logic [HASH_W-1:0] rh_red_ff, rh_red_in;
   logic [HASH_W-1:0] base_red_ff, base_red_in;
   logic [HASH_W-1:0] byte_red_ff, byte_red_in;
   logic [HASH_W-1:0] acc_h_ff, acc_h_in;
   logic [HASH_W-1:0] acc_p_ff, acc_p_in;
   logic              last_ff, last_in;
   logic [HASH_W-1:0] hash_ff, hash_in;
   logic [IDX_W-1:0]  bkt_acc_ff, bkt_acc_in;
   logic              rsp_tvalid_ff, rsp_tvalid_in;
   logic [HASH_W-1:0] rsp_hash_ff, rsp_hash_in;
   logic [IDX_W-1:0]  rsp_idx_ff, rsp_idx_in;

   logic [HASH_W-1:0] rh_red_nx, base_red_nx, byte_red_nx;
   logic [HASH_W-1:0] h_nx, p_nx, bkt_nx;

   assign req_tready = ctl.idle;
   assign rsp_busy   = rsp_tvalid_ff && !rsp_tready;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{(RSP_D_W - HASH_W - IDX_W){1'b0}}, rsp_idx_ff, rsp_hash_ff};

   assign m_eff = (mod_cfg_ff == '0) ? HASH_W'(1) : mod_cfg_ff;

   always_comb begin
      if (bkt_cfg_ff == '0) begin
         bkt_eff = HASH_W'(1);
      end else if (bkt_cfg_ff > BUCKET_MAX) begin
         bkt_eff = HASH_W'(BUCKET_MAX);
      end else begin
         bkt_eff = HASH_W'(bkt_cfg_ff);
      end
   end

   prh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .last_key  (last_ff),
      .rsp_busy  (rsp_busy),
      .ctl       (ctl)
   );

   prh_mod_step u_red_rh (
      .acc (rh_red_ff), .addend (HASH_W'(1)), .add_en (rh_sr_ff[HASH_W-1]),
      .dbl (1'b1), .modulus (m_eff), .res (rh_red_nx)
   );

   prh_mod_step u_red_base (
      .acc (base_red_ff), .addend (HASH_W'(1)), .add_en (base_sr_ff[HASH_W-1]),
      .dbl (1'b1), .modulus (m_eff), .res (base_red_nx)
   );

   prh_mod_step u_red_byte (
      .acc (byte_red_ff), .addend (HASH_W'(1)), .add_en (byte_sr_ff[HASH_W-1]),
      .dbl (1'b1), .modulus (m_eff), .res (byte_red_nx)
   );

   // hash product during multiply, then the old hash added without doubling
   prh_mod_step u_mul_h (
      .acc     (acc_h_ff),
      .addend  (ctl.mul ? byte_red_ff : rh_red_ff),
      .add_en  (ctl.mul ? bp_sr_ff[HASH_W-1] : 1'b1),
      .dbl     (ctl.mul),
      .modulus (m_eff),
      .res     (h_nx)
   );

   prh_mod_step u_mul_p (
      .acc (acc_p_ff), .addend (base_red_ff), .add_en (bp_sr_ff[HASH_W-1]),
      .dbl (1'b1), .modulus (m_eff), .res (p_nx)
   );

   prh_mod_step u_bkt (
      .acc (HASH_W'(bkt_acc_ff)), .addend (HASH_W'(1)), .add_en (hash_ff[HASH_W-1]),
      .dbl (1'b1), .modulus (bkt_eff), .res (bkt_nx)
   );

   always_comb begin
      base_cfg_in = base_cfg_ff;
      mod_cfg_in  = mod_cfg_ff;
      bkt_cfg_in  = bkt_cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_HASH_BASE:    base_cfg_in = csr_wdata;
            CSR_HASH_MODULUS: mod_cfg_in  = csr_wdata;
            CSR_BUCKET_COUNT: bkt_cfg_in  = csr_wdata[BKT_W-1:0];
            default: begin
               base_cfg_in = base_cfg_ff;
            end
         endcase
      end
   end

   always_comb begin
      rh_in       = rh_ff;
      bp_in       = bp_ff;
      rh_sr_in    = rh_sr_ff;
      base_sr_in  = base_sr_ff;
      byte_sr_in  = byte_sr_ff;
      bp_sr_in    = bp_sr_ff;
      rh_red_in   = rh_red_ff;
      base_red_in = base_red_ff;
      byte_red_in = byte_red_ff;
      acc_h_in    = acc_h_ff;
      acc_p_in    = acc_p_ff;
      last_in     = last_ff;
      hash_in     = hash_ff;
      bkt_acc_in  = bkt_acc_ff;

      if (ctl.load) begin
         rh_sr_in    = rh_ff;
         base_sr_in  = base_cfg_ff;
         byte_sr_in  = HASH_W'(req_tdata);
         bp_sr_in    = bp_ff;
         rh_red_in   = '0;
         base_red_in = '0;
         byte_red_in = '0;
         acc_h_in    = '0;
         acc_p_in    = '0;
         last_in     = req_tlast;
      end

      if (ctl.reduce) begin
         rh_red_in   = rh_red_nx;
         base_red_in = base_red_nx;
         byte_red_in = byte_red_nx;
         rh_sr_in    = {rh_sr_ff[HASH_W-2:0], 1'b0};
         base_sr_in  = {base_sr_ff[HASH_W-2:0], 1'b0};
         byte_sr_in  = {byte_sr_ff[HASH_W-2:0], 1'b0};
      end

      if (ctl.mul) begin
         acc_h_in = h_nx;
         acc_p_in = p_nx;
         bp_sr_in = {bp_sr_ff[HASH_W-2:0], 1'b0};
      end

      if (ctl.add) begin
         if (last_ff) begin
            rh_in      = '0;
            bp_in      = HASH_W'(1);
            hash_in    = h_nx;
            bkt_acc_in = '0;
         end else begin
            rh_in = h_nx;
            bp_in = acc_p_ff;
         end
      end

      // rotate, so the hash is whole again after the last bit
      if (ctl.bucket) begin
         bkt_acc_in = bkt_nx[IDX_W-1:0];
         hash_in    = {hash_ff[HASH_W-2:0], hash_ff[HASH_W-1]};
      end
   end

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_hash_in   = rsp_hash_ff;
      rsp_idx_in    = rsp_idx_ff;
      if (ctl.emit) begin
         rsp_tvalid_in = 1'b1;
         rsp_hash_in   = hash_ff;
         rsp_idx_in    = bkt_acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_cfg_ff   <= BASE_RST;
         mod_cfg_ff    <= MODULUS_RST;
         bkt_cfg_ff    <= BUCKET_RST;
         rh_ff         <= '0;
         bp_ff         <= HASH_W'(1);
         last_ff       <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         base_cfg_ff   <= base_cfg_in;
         mod_cfg_ff    <= mod_cfg_in;
         bkt_cfg_ff    <= bkt_cfg_in;
         rh_ff         <= rh_in;
         bp_ff         <= bp_in;
         last_ff       <= last_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rh_sr_ff    <= rh_sr_in;
      base_sr_ff  <= base_sr_in;
      byte_sr_ff  <= byte_sr_in;
      bp_sr_ff    <= bp_sr_in;
      rh_red_ff   <= rh_red_in;
      base_red_ff <= base_red_in;
      byte_red_ff <= byte_red_in;
      acc_h_ff    <= acc_h_in;
      acc_p_ff    <= acc_p_in;
      hash_ff     <= hash_in;
      bkt_acc_ff  <= bkt_acc_in;
      rsp_hash_ff <= rsp_hash_in;
      rsp_idx_ff  <= rsp_idx_in;
   end

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(ctl.emit))
      else $error("result beat raised without an emit");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctl.emit |-> (!rsp_tvalid_ff || rsp_tready))
      else $error("pending result beat overwritten");

   a_key_restart: assert property (@(posedge clock) disable iff (reset)
      (ctl.add && last_ff) |=> (rh_ff == '0 && bp_ff == HASH_W'(1)))
      else $error("hash state not restarted after last byte");

endmodule

[src/prh_mod_step.sv]
// one bit step of modular shift-and-add: (dbl ? 2*acc : acc) + bit*addend mod modulus
module prh_mod_step (
   input  logic [prh_pkg::HASH_W-1:0] acc,
   input  logic [prh_pkg::HASH_W-1:0] addend,
   input  logic                       add_en,
   input  logic                       dbl,
   input  logic [prh_pkg::HASH_W-1:0] modulus,
   output logic [prh_pkg::HASH_W-1:0] res
);
   import prh_pkg::*;

   logic [HASH_W+1:0] sum;
   logic [HASH_W+1:0] m1;
   logic [HASH_W+1:0] m2;

   // inputs stay below the modulus, so the sum stays below three times it
   always_comb begin
      m1  = {2'b00, modulus};
      m2  = {1'b0, modulus, 1'b0};
      sum = (dbl ? {1'b0, acc, 1'b0} : {2'b00, acc})
            + (add_en ? {2'b00, addend} : '0);
      if (sum >= m2) begin
         res = HASH_W'(sum - m2);
      end else if (sum >= m1) begin
         res = HASH_W'(sum - m1);
      end else begin
         res = HASH_W'(sum);
      end
   end

endmodule

[src/prh_ctrl.sv]
// sequencer of the reduce, multiply, accumulate and bucket phases
module prh_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             last_key,
   input  logic             rsp_busy,
   output prh_pkg::ctl_type ctl
);
   import prh_pkg::*;

   state_type        state_ff;
   state_type        state_in;
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;
   logic             cnt_done;

   assign cnt_done = (cnt_ff == CNT_W'(HASH_W - 1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_REDUCE;
         end
         ST_REDUCE: begin
            if (cnt_done) state_in = ST_MUL;
         end
         ST_MUL: begin
            if (cnt_done) state_in = ST_ADD;
         end
         ST_ADD: begin
            state_in = last_key ? ST_BUCKET : ST_IDLE;
         end
         ST_BUCKET: begin
            if (cnt_done) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_busy) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      cnt_in = (state_in != state_ff) ? '0 : cnt_ff + 1'b1;
   end

   // ready is high throughout idle, so a valid beat there is accepted
   always_comb begin
      ctl = '0;
      case (state_ff)
         ST_IDLE: begin
            ctl.idle = 1'b1;
            ctl.load = req_valid;
         end
         ST_REDUCE: begin
            ctl.reduce = 1'b1;
         end
         ST_MUL: begin
            ctl.mul = 1'b1;
         end
         ST_ADD: begin
            ctl.add = 1'b1;
         end
         ST_BUCKET: begin
            ctl.bucket = 1'b1;
         end
         ST_OUT: begin
            ctl.emit = !rsp_busy;
         end
         default: begin
            ctl = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule
